/* sv/dnsqb_pkg.sv */
`default_nettype none

package dnsqb_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int OFF_W = 9;
  localparam int LEN_W = 7;

  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_BSL = 8'h5C;
  localparam logic [7:0] FLAGS_RD = 8'h01;
  localparam logic [7:0] QDCOUNT_LO = 8'h01;
  localparam logic [7:0] CLASS_IN_LO = 8'h01;

  typedef logic [4:0] step_t;

  localparam step_t STEP_PRE      = 5'd0;
  localparam step_t STEP_LABEL    = 5'd1;
  localparam step_t STEP_ZERO     = 5'd2;
  localparam step_t STEP_TYPE_HI  = 5'd3;
  localparam step_t STEP_TYPE_LO  = 5'd4;
  localparam step_t STEP_CLASS_HI = 5'd5;
  localparam step_t STEP_CLASS_LO = 5'd6;
  localparam step_t STEP_HDR_FIRST = 5'd7;
  localparam step_t STEP_HDR_LAST  = 5'd18;
  localparam step_t STEP_STATUS   = 5'd19;

  localparam logic [3:0] HDR_ID_HI   = 4'd0;
  localparam logic [3:0] HDR_ID_LO   = 4'd1;
  localparam logic [3:0] HDR_FLAGS   = 4'd2;
  localparam logic [3:0] HDR_QD_LO   = 4'd5;

  typedef struct packed {
    logic             end_item;
    logic             err;
    logic             pre_v;
    logic [OFF_W-1:0] pre_off;
    logic [7:0]       pre_val;
    logic             lab_v;
    logic [OFF_W-1:0] lab_off;
    logic [LEN_W-1:0] lab_len;
    logic [OFF_W-1:0] z;
  } desc_t;

endpackage

`default_nettype wire

/* sv/dns_query_packet_builder_unit.sv */
`default_nettype none

// Channel   Beat content (tdata from bit 0 up)                         tlast        tuser
// s_axis    name_byte[7:0], query_id[23:8], query_type[39:24]          end_of_name  has_byte
// m_axis    byte_offset[8:0], byte_value[16:9], status[17],            done_res     -
//           packet_length[26:18], zero fill[31:27]
// A character beat is taken every cycle unless the output stalls and gives at most one
// write beat via the descriptor and output registers. The last beat of a name starts a
// burst of up to 20 result beats, one per cycle unless the output stalls, issued by the
// step sequencer; input is held off until the burst reaches its status beat.
// A synchronous reset clears the name state and drops any pending beats.
// Output stalls hold the output register and, through it, the sequencer and the input.

module dns_query_packet_builder_unit #(
  parameter int MAX_LABEL_BYTES = 63,
  parameter int MAX_NAME_BYTES  = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // name_byte, query_id, query_type
  input  wire logic        s_tlast,   // end_of_name
  input  wire logic        s_tuser,   // has_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // byte_offset, byte_value, status, packet_length
  output logic             m_tlast    // done_res
);
  import dnsqb_pkg::*;

  localparam logic [LEN_W-1:0] LABEL_LIMIT   = LEN_W'(MAX_LABEL_BYTES);
  localparam logic [OFF_W-1:0] NAME_LIMIT    = OFF_W'(MAX_NAME_BYTES + HEADER_BYTES - 2);
  localparam logic [OFF_W-1:0] HEADER_OFFSET = OFF_W'(HEADER_BYTES);

  logic [OFF_W-1:0] next_offset;
  logic [OFF_W-1:0] label_start;
  logic [LEN_W-1:0] label_length;
  logic             escape_pending;
  logic             name_error;
  logic             first_item;
  logic [15:0]      held_id;
  logic [15:0]      held_type;

  desc_t            desc;
  logic             desc_valid;
  step_t            step;

  logic [7:0]       in_byte;
  logic             in_has;
  logic             in_end;
  logic             accept;

  logic [OFF_W-1:0] no_next;
  logic [OFF_W-1:0] ls_next;
  logic [LEN_W-1:0] ll_next;
  logic             esc_next;
  logic             err_next;
  logic             do_add;
  logic [7:0]       add_char;
  logic             add_v;
  logic [OFF_W-1:0] add_off;
  logic             close_v;
  logic [OFF_W-1:0] close_off;
  logic [LEN_W-1:0] close_len;
  desc_t            desc_next;
  step_t            start_step;

  logic             out_load;
  logic             last_step;
  step_t            step_next;
  logic [OFF_W-1:0] r_off;
  logic [7:0]       r_val;
  logic             r_done;
  logic             r_status;
  logic [OFF_W-1:0] r_len;
  logic [4:0]       hdr_diff;
  logic [3:0]       hdr_idx;

  assign in_byte = s_tdata[7:0];
  assign in_has  = s_tuser;
  assign in_end  = s_tlast;
  assign accept  = s_tvalid && s_tready;

  always_comb begin
    no_next   = next_offset;
    ls_next   = label_start;
    ll_next   = label_length;
    esc_next  = escape_pending;
    err_next  = name_error;
    do_add    = 1'b0;
    add_char  = in_byte;
    close_v   = 1'b0;
    close_off = label_start;
    close_len = label_length;
    add_v     = 1'b0;

    if (in_has && !err_next) begin
      if (esc_next) begin
        esc_next = 1'b0;
        do_add   = 1'b1;
      end else if (in_byte == CHAR_BSL) begin
        esc_next = 1'b1;
      end else if (in_byte == CHAR_DOT) begin
        if (ll_next == '0) begin
          if (!(in_end && ls_next == HEADER_OFFSET)) begin
            err_next = 1'b1;
          end
        end else begin
          close_v = 1'b1;
          ls_next = OFF_W'(no_next + 1'b1);
          no_next = ls_next;
          ll_next = '0;
        end
      end else begin
        do_add = 1'b1;
      end
    end

    if (in_end && esc_next && !err_next) begin
      do_add   = 1'b1;
      add_char = CHAR_BSL;
    end
    if (in_end) begin
      esc_next = 1'b0;
    end

    add_off = OFF_W'(no_next + 1'b1);
    if (do_add && !err_next) begin
      if (ll_next >= LABEL_LIMIT) begin
        err_next = 1'b1;
      end else if (add_off > NAME_LIMIT) begin
        err_next = 1'b1;
      end else begin
        add_v   = 1'b1;
        no_next = add_off;
        ll_next = LEN_W'(ll_next + 1'b1);
      end
    end

    desc_next.end_item = in_end;
    desc_next.err      = err_next;
    desc_next.pre_v    = close_v || add_v;
    desc_next.pre_off  = close_v ? close_off : add_off;
    desc_next.pre_val  = close_v ? {1'b0, close_len} : add_char;
    desc_next.lab_v    = (ll_next != '0);
    desc_next.lab_off  = ls_next;
    desc_next.lab_len  = ll_next;
    desc_next.z        = (ll_next != '0) ? OFF_W'(no_next + 1'b1) : ls_next;

    if (in_end && err_next) begin
      start_step = STEP_STATUS;
    end else if (desc_next.pre_v || !in_end) begin
      start_step = STEP_PRE;
    end else if (desc_next.lab_v) begin
      start_step = STEP_LABEL;
    end else begin
      start_step = STEP_ZERO;
    end
  end

  always_comb begin
    r_off    = '0;
    r_val    = '0;
    r_done   = 1'b0;
    r_status = 1'b0;
    r_len    = '0;
    hdr_diff = step - STEP_HDR_FIRST;
    hdr_idx  = hdr_diff[3:0];
    case (step) inside
      STEP_PRE: begin
        r_off = desc.pre_off;
        r_val = desc.pre_val;
      end
      STEP_LABEL: begin
        r_off = desc.lab_off;
        r_val = {1'b0, desc.lab_len};
      end
      STEP_ZERO: begin
        r_off = desc.z;
      end
      STEP_TYPE_HI: begin
        r_off = OFF_W'(desc.z + 9'd1);
        r_val = held_type[15:8];
      end
      STEP_TYPE_LO: begin
        r_off = OFF_W'(desc.z + 9'd2);
        r_val = held_type[7:0];
      end
      STEP_CLASS_HI: begin
        r_off = OFF_W'(desc.z + 9'd3);
      end
      STEP_CLASS_LO: begin
        r_off = OFF_W'(desc.z + 9'd4);
        r_val = CLASS_IN_LO;
      end
      [STEP_HDR_FIRST:STEP_HDR_LAST]: begin
        r_off = OFF_W'(hdr_idx);
        case (hdr_idx)
          HDR_ID_HI: r_val = held_id[15:8];
          HDR_ID_LO: r_val = held_id[7:0];
          HDR_FLAGS: r_val = FLAGS_RD;
          HDR_QD_LO: r_val = QDCOUNT_LO;
          default:   r_val = '0;
        endcase
      end
      STEP_STATUS: begin
        r_done   = 1'b1;
        r_status = desc.err;
        r_len    = desc.err ? '0 : OFF_W'(desc.z + 9'd5);
      end
      default: begin
      end
    endcase
  end

  assign out_load  = desc_valid && (!m_tvalid || m_tready);
  assign last_step = (!desc.end_item && step == STEP_PRE) || step == STEP_STATUS;
  assign s_tready  = !desc_valid || (out_load && last_step);

  always_comb begin
    if (step == STEP_PRE) begin
      step_next = desc.lab_v ? STEP_LABEL : STEP_ZERO;
    end else begin
      step_next = step_t'(step + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_offset    <= HEADER_OFFSET;
      label_start    <= HEADER_OFFSET;
      label_length   <= '0;
      escape_pending <= 1'b0;
      name_error     <= 1'b0;
      first_item     <= 1'b1;
      held_id        <= '0;
      held_type      <= '0;
      desc_valid     <= 1'b0;
      step           <= STEP_PRE;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept) begin
        if (first_item) begin
          held_id   <= s_tdata[23:8];
          held_type <= s_tdata[39:24];
        end
        if (in_end) begin
          next_offset    <= HEADER_OFFSET;
          label_start    <= HEADER_OFFSET;
          label_length   <= '0;
          escape_pending <= 1'b0;
          name_error     <= 1'b0;
          first_item     <= 1'b1;
        end else begin
          next_offset    <= no_next;
          label_start    <= ls_next;
          label_length   <= ll_next;
          escape_pending <= esc_next;
          name_error     <= err_next;
          first_item     <= 1'b0;
        end
      end

      if (accept && (desc_next.pre_v || in_end)) begin
        desc_valid <= 1'b1;
        desc       <= desc_next;
        step       <= start_step;
      end else if (out_load) begin
        if (last_step) begin
          desc_valid <= 1'b0;
        end else begin
          step <= step_next;
        end
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {5'd0, r_len, r_status, r_val, r_off};
        m_tlast  <= r_done;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/dnsqb_checker.sv */
`default_nettype none

module dnsqb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic        m_tlast,
  input wire logic [31:0] m_tdata
);

  // A stalled result beat keeps its content.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result beat changed");

  // The status beat carries no byte write.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[16:0] == 17'd0)
    else $error("status beat carries a byte write");

  // A byte write carries no status and no length.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[26:17] == 10'd0)
    else $error("byte write carries status fields");

  // A failed name reports a zero length.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && m_tdata[17] |-> m_tdata[26:18] == 9'd0)
    else $error("failed name reports a length");

  // Reset leaves nothing pending and the input open.
  assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("beats pending after reset");

endmodule

bind dns_query_packet_builder_unit dnsqb_checker u_dnsqb_checker (.*);

`default_nettype wire
